### hw/rtl/ipv6_text_formatter_unit_defines.svh
// Assertion helpers used by the checker file.
`ifndef IPV6_TEXT_FORMATTER_UNIT_DEFINES_SVH
`define IPV6_TEXT_FORMATTER_UNIT_DEFINES_SVH

// Same-cycle implication, off during reset.
`define IPV6FMT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define IPV6FMT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also covers reset itself.
`define IPV6FMT_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/ipv6fmt_pkg.sv
package ipv6fmt_pkg;

  localparam int GroupCount = 8;
  localparam int GroupWidth = 16;
  localparam int MinRun     = 2;
  localparam int QueueDepth = 2;

  localparam logic [6:0] ColonChar = 7'h3a;
  localparam logic [6:0] ZeroChar  = 7'h30;
  localparam logic [6:0] AlphaChar = 7'h61;

  typedef struct packed {
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic [2:0]  run_start;
    logic [3:0]  run_end;   // one past the last zero group of the run
    logic        comp;      // run is long enough to collapse into "::"
  } fmt_entry_t;

  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] c;
    if (nib < 4'd10) begin
      c = ZeroChar + {3'b000, nib};
    end else begin
      c = AlphaChar + {3'b000, nib - 4'd10};
    end
    return c;
  endfunction

  // Index of the most significant printed digit (leading zeros dropped).
  function automatic logic [1:0] top_digit(input logic [GroupWidth-1:0] g);
    logic [1:0] d;
    if (g[15:12] != 4'h0) begin
      d = 2'd3;
    end else if (g[11:8] != 4'h0) begin
      d = 2'd2;
    end else if (g[7:4] != 4'h0) begin
      d = 2'd1;
    end else begin
      d = 2'd0;
    end
    return d;
  endfunction

endpackage

### hw/rtl/ipv6fmt_front.sv
module ipv6fmt_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  logic [63:0]             address_high,
  input  logic [63:0]             address_low,
  output logic                    q_push,
  output ipv6fmt_pkg::fmt_entry_t q_entry,
  input  logic                    q_full
);

  logic        f_valid;
  logic        f_valid_next;
  logic [63:0] f_high;
  logic [63:0] f_low;
  logic        accept;

  logic [127:0] word;
  logic [3:0]   cur_len;
  logic [2:0]   cur_start;
  logic [3:0]   best_len;
  logic [2:0]   best_start;

  assign full   = f_valid && q_full;
  assign accept = push && !full;
  assign q_push = f_valid && !q_full;

  always_comb begin
    if (accept) begin
      f_valid_next = 1'b1;
    end else if (!q_full) begin
      f_valid_next = 1'b0;
    end else begin
      f_valid_next = f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= f_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_high <= address_high;
      f_low  <= address_low;
    end
  end

  // Find the first longest run of zero groups.
  always_comb begin
    word       = {f_high, f_low};
    cur_len    = 4'd0;
    cur_start  = 3'd0;
    best_len   = 4'd0;
    best_start = 3'd0;
    for (int i = 0; i < ipv6fmt_pkg::GroupCount; i++) begin
      if (word[127 - ipv6fmt_pkg::GroupWidth * i -: ipv6fmt_pkg::GroupWidth] == '0) begin
        if (cur_len == 4'd0) begin
          cur_start = 3'(i);
        end
        cur_len = cur_len + 4'd1;
        if (cur_len > best_len) begin
          best_len   = cur_len;
          best_start = cur_start;
        end
      end else begin
        cur_len = 4'd0;
      end
    end
  end

  always_comb begin
    q_entry.address_high = f_high;
    q_entry.address_low  = f_low;
    q_entry.run_start    = best_start;
    q_entry.run_end      = {1'b0, best_start} + best_len;
    q_entry.comp         = best_len >= 4'(ipv6fmt_pkg::MinRun);
  end

endmodule

### hw/rtl/ipv6fmt_queue.sv
module ipv6fmt_queue #(
  parameter int QueueDepth = ipv6fmt_pkg::QueueDepth
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  ipv6fmt_pkg::fmt_entry_t din,
  input  logic                    pop,
  output logic                    empty,
  output ipv6fmt_pkg::fmt_entry_t dout
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  ipv6fmt_pkg::fmt_entry_t slots [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full    = count == CntW'(QueueDepth);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

### hw/rtl/ipv6fmt_back.sv
module ipv6fmt_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_empty,
  input  ipv6fmt_pkg::fmt_entry_t q_head,
  output logic                    q_pop,
  output logic [6:0]              text_char,
  output logic                    last_char,
  output logic                    empty,
  input  logic                    pop
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SEP  = 3'd1;
  localparam logic [2:0] ST_DIG  = 3'd2;
  localparam logic [2:0] ST_DC1  = 3'd3;
  localparam logic [2:0] ST_DC2  = 3'd4;

  typedef struct packed {
    logic [2:0] state;
    logic [2:0] grp;
    logic [1:0] dig;
  } step_t;

  function automatic logic [15:0] group_of(input ipv6fmt_pkg::fmt_entry_t e,
                                           input logic [2:0] idx);
    logic [127:0] w;
    logic [2:0]   sel;
    w   = {e.address_high, e.address_low};
    sel = ~idx;
    return w[{sel, 4'b0000} +: 16];
  endfunction

  // Step taken on arriving at group idx (idx of eight means the text is done).
  function automatic step_t enter(input ipv6fmt_pkg::fmt_entry_t e,
                                  input logic [3:0] idx);
    step_t s;
    s.grp   = idx[2:0];
    s.dig   = 2'd0;
    if (idx[3]) begin
      s.state = ST_IDLE;
      s.grp   = 3'd0;
    end else if (e.comp && idx[2:0] == e.run_start) begin
      s.state = ST_DC1;
    end else if (idx != 4'd0 && !(e.comp && idx == e.run_end)) begin
      s.state = ST_SEP;
    end else begin
      s.state = ST_DIG;
      s.dig   = ipv6fmt_pkg::top_digit(group_of(e, idx[2:0]));
    end
    return s;
  endfunction

  ipv6fmt_pkg::fmt_entry_t ent;
  step_t      cur;
  step_t      nxt;
  step_t      cur_next;
  logic [15:0] cur_g;
  logic [6:0]  ch;
  logic        busy;
  logic        emit;
  logic        o_valid;
  logic        o_valid_next;
  logic        pop_ok;

  assign busy   = cur.state != ST_IDLE;
  assign pop_ok = pop && o_valid;
  assign emit   = busy && (!o_valid || pop_ok);
  assign q_pop  = !busy && !q_empty;
  assign empty  = !o_valid;
  assign cur_g  = group_of(ent, cur.grp);

  always_comb begin
    ch  = ipv6fmt_pkg::ColonChar;
    nxt = '{state: ST_IDLE, grp: 3'd0, dig: 2'd0};
    case (cur.state)
      ST_DC1: begin
        nxt = '{state: ST_DC2, grp: cur.grp, dig: 2'd0};
      end
      ST_DC2: begin
        nxt = enter(ent, ent.run_end);
      end
      ST_SEP: begin
        nxt = '{state: ST_DIG, grp: cur.grp, dig: ipv6fmt_pkg::top_digit(cur_g)};
      end
      ST_DIG: begin
        ch = ipv6fmt_pkg::hex_char(cur_g[{cur.dig, 2'b00} +: 4]);
        if (cur.dig == 2'd0) begin
          nxt = enter(ent, {1'b0, cur.grp} + 4'd1);
        end else begin
          nxt = '{state: ST_DIG, grp: cur.grp, dig: cur.dig - 2'd1};
        end
      end
      default: begin
        nxt = '{state: ST_IDLE, grp: 3'd0, dig: 2'd0};
      end
    endcase
  end

  always_comb begin
    if (q_pop) begin
      cur_next = enter(q_head, 4'd0);
    end else if (emit) begin
      cur_next = nxt;
    end else begin
      cur_next = cur;
    end
  end

  always_comb begin
    if (emit) begin
      o_valid_next = 1'b1;
    end else if (pop_ok) begin
      o_valid_next = 1'b0;
    end else begin
      o_valid_next = o_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur     <= '{state: ST_IDLE, grp: 3'd0, dig: 2'd0};
      o_valid <= 1'b0;
    end else begin
      cur     <= cur_next;
      o_valid <= o_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ent <= q_head;
    end
    if (emit) begin
      text_char <= ch;
      last_char <= nxt.state == ST_IDLE;
    end
  end

endmodule

### hw/rtl/ipv6_text_formatter_unit.sv
// IPv6 address to compressed text (lowercase hex, longest zero run of two or more groups as "::").
// Input side is a queue write port: present address_high/address_low with
// push; the beat is taken when push is high and full is low.
// Output side is a queue read port: while empty is low, text_char holds the
// oldest character and last_char marks the final character of an address;
// pop with empty low takes the beat.
// The front stage registers the address and finds the zero run, a two-entry
// queue holds classified addresses, and the back sequencer prints one character
// per cycle into an output register while the reader keeps popping.
// An address passes the front register, a queue slot and the sequencer's
// entry register before its first character shows. An address prints as
// 2 to 39 characters; the back sequencer takes the next address only once
// idle, and the front keeps taking addresses while the queue has room.
// Reset clears the front valid, the queue pointers, the sequencer and the
// output valid flag; empty is high after reset.
// When pop is held low the current character holds, the sequencer stops,
// and full rises once the queue and the front stage are occupied.
module ipv6_text_formatter_unit #(
  parameter int QueueDepth = ipv6fmt_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [63:0] address_high,
  input  logic [63:0] address_low,
  output logic        empty,
  input  logic        pop,
  output logic [6:0]  text_char,
  output logic        last_char
);

  logic                    q_push;
  logic                    q_full;
  logic                    q_pop;
  logic                    q_empty;
  ipv6fmt_pkg::fmt_entry_t q_entry;
  ipv6fmt_pkg::fmt_entry_t q_head;

  ipv6fmt_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .address_high (address_high),
    .address_low  (address_low),
    .q_push       (q_push),
    .q_entry      (q_entry),
    .q_full       (q_full)
  );

  ipv6fmt_queue #(
    .QueueDepth (QueueDepth)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .full  (q_full),
    .din   (q_entry),
    .pop   (q_pop),
    .empty (q_empty),
    .dout  (q_head)
  );

  ipv6fmt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .text_char (text_char),
    .last_char (last_char),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

### hw/rtl/ipv6fmt_checker.sv
`include "ipv6_text_formatter_unit_defines.svh"

module ipv6fmt_checker (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic [6:0] text_char,
  input logic       last_char
);

  `IPV6FMT_ASSERT_RST(a_empty_after_rst, rst, empty, "result shown right after reset")

  `IPV6FMT_ASSERT_IMP(a_char_legal, !empty, (text_char >= 7'h30 && text_char <= 7'h39) || (text_char >= 7'h61 && text_char <= 7'h66) || text_char == 7'h3a, "illegal text character")

  `IPV6FMT_ASSERT_NXT(a_stall_holds, !empty && !pop, !empty && $stable(text_char) && $stable(last_char), "stalled character changed")

  // Characters of one address come back to back once the reader takes them.
  `IPV6FMT_ASSERT_NXT(a_text_continues, !empty && pop && !last_char, !empty, "gap inside address text")

endmodule

bind ipv6_text_formatter_unit ipv6fmt_checker u_checker (.*);
